// File: hw/rtl/rcnh_pkg.sv
// rcnh_pkg: shared types, widths and constants of the ray/cube nearest-hit block.
// No dependencies.
package rcnh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int NUM_W     = 33 + FRAC_BITS;   // |plane - origin| << FRAC_BITS
    localparam int QW        = NUM_W;            // unsigned quotient width
    localparam int DIV_CELLS = QW;               // one quotient bit per cell
    localparam int DIVS      = 6;                // one divider lane per face
    localparam logic [30:0] HALF_RESET = 31'd65536;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        logic signed [W-1:0] oz;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] dz;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        logic [30:0]         half;
    } ray_t;

    // Per-face division lane: partial remainder, dividend, quotient, divisor, sign, skip.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [QW-1:0]    quo;
        logic [W-1:0]     den;
        logic             qneg;
        logic             skip;
    } div_lane_t;

    typedef div_lane_t [DIVS-1:0] lanes_t;

    // floor(v / 2^FRAC_BITS) is an arithmetic right shift
    function automatic logic signed [65:0] fshift(input logic signed [65:0] v);
        fshift = v >>> FRAC_BITS;
    endfunction

    function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[W-1:0];
    endfunction

endpackage

// File: hw/rtl/rcnh_div_cell.sv
// rcnh_div_cell: one restoring-division step for all six face lanes plus ray carry.
// Depends on rcnh_pkg.
module rcnh_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vld_in,
    input  rcnh_pkg::ray_t         ray_in,
    input  rcnh_pkg::lanes_t       lanes_in,
    output logic                   vld_out,
    output rcnh_pkg::ray_t         ray_out,
    output rcnh_pkg::lanes_t       lanes_out
);
    logic               vld_reg;
    rcnh_pkg::ray_t     ray_reg;
    rcnh_pkg::lanes_t   lanes_reg;
    rcnh_pkg::lanes_t   lanes_next;

    always_comb
    begin
        for (int i = 0; i < rcnh_pkg::DIVS; i++)
        begin
            logic [rcnh_pkg::NUM_W:0] trial;
            trial = {lanes_in[i].rem, lanes_in[i].num[rcnh_pkg::NUM_W-1]};
            lanes_next[i] = lanes_in[i];
            lanes_next[i].num = {lanes_in[i].num[rcnh_pkg::NUM_W-2:0], 1'b0};
            if (trial >= {{(rcnh_pkg::NUM_W+1-rcnh_pkg::W){1'b0}}, lanes_in[i].den})
            begin
                trial = trial - {{(rcnh_pkg::NUM_W+1-rcnh_pkg::W){1'b0}}, lanes_in[i].den};
                lanes_next[i].quo = {lanes_in[i].quo[rcnh_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                lanes_next[i].quo = {lanes_in[i].quo[rcnh_pkg::QW-2:0], 1'b0};
            end
            lanes_next[i].rem = trial[rcnh_pkg::NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        ray_reg   <= ray_in;
        lanes_reg <= lanes_next;
    end

    assign vld_out   = vld_reg;
    assign ray_out   = ray_reg;
    assign lanes_out = lanes_reg;
endmodule

// File: hw/rtl/rcnh_face_tail.sv
// rcnh_face_tail: t saturation, hit-point products, square and interval tests,
// nearest-face selection and output position. Depends on rcnh_pkg.
module rcnh_face_tail (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vld_in,
    input  rcnh_pkg::ray_t         ray_in,
    input  rcnh_pkg::lanes_t       lanes_in,
    output logic                   strobe,
    output logic                   hit,
    output logic signed [31:0]     hit_t,
    output logic signed [31:0]     pos_x,
    output logic signed [31:0]     pos_y,
    output logic signed [31:0]     pos_z,
    output logic [1:0]             face_axis,
    output logic                   face_negative
);
    // stage A: saturated t per face
    logic                   a_vld_reg;
    rcnh_pkg::ray_t         a_ray_reg;
    logic signed [31:0]     a_t_reg [6];
    logic [5:0]             a_ok_reg;
    logic signed [31:0]     a_t_next [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            logic [rcnh_pkg::QW-1:0] q;
            q = lanes_in[i].quo;
            if (lanes_in[i].qneg)
                a_t_next[i] = (q > rcnh_pkg::QW'(33'h80000000)) ? 32'sh80000000
                                                                : -q[31:0];
            else
                a_t_next[i] = (q > rcnh_pkg::QW'(32'h7fffffff)) ? 32'sh7fffffff
                                                                : q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        a_ray_reg <= ray_in;
        for (int i = 0; i < 6; i++)
        begin
            a_t_reg[i]  <= a_t_next[i];
            a_ok_reg[i] <= !lanes_in[i].skip;
        end
    end

    // stage B: products of the two other direction components with t
    logic                   b_vld_reg;
    rcnh_pkg::ray_t         b_ray_reg;
    logic signed [31:0]     b_t_reg [6];
    logic [5:0]             b_ok_reg;
    logic signed [63:0]     b_pb_reg [6];
    logic signed [63:0]     b_pc_reg [6];

    function automatic logic signed [31:0] dsel(input rcnh_pkg::ray_t r, input int ax);
        dsel = (ax == 0) ? r.dx : (ax == 1) ? r.dy : r.dz;
    endfunction

    function automatic logic signed [31:0] osel(input rcnh_pkg::ray_t r, input int ax);
        osel = (ax == 0) ? r.ox : (ax == 1) ? r.oy : r.oz;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_ray_reg <= a_ray_reg;
        b_ok_reg  <= a_ok_reg;
        for (int i = 0; i < 6; i++)
        begin
            b_t_reg[i]  <= a_t_reg[i];
            b_pb_reg[i] <= dsel(a_ray_reg, ((i >> 1) + 1) % 3) * a_t_reg[i];
            b_pc_reg[i] <= dsel(a_ray_reg, ((i >> 1) + 2) % 3) * a_t_reg[i];
        end
    end

    // stage C: square and interval tests
    logic                   c_vld_reg;
    rcnh_pkg::ray_t         c_ray_reg;
    logic signed [31:0]     c_t_reg [6];
    logic [5:0]             c_ok_reg;
    logic [5:0]             c_ok_next;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            logic signed [65:0] pb, pc, h;
            pb = 66'(osel(b_ray_reg, ((i >> 1) + 1) % 3))
               + rcnh_pkg::fshift(66'(b_pb_reg[i]));
            pc = 66'(osel(b_ray_reg, ((i >> 1) + 2) % 3))
               + rcnh_pkg::fshift(66'(b_pc_reg[i]));
            h  = 66'($unsigned(b_ray_reg.half));
            c_ok_next[i] = b_ok_reg[i] && pb <= h && pb >= -h && pc <= h && pc >= -h
                         && b_t_reg[i] >= b_ray_reg.lo && b_t_reg[i] <= b_ray_reg.hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        c_ray_reg <= b_ray_reg;
        c_ok_reg  <= c_ok_next;
        for (int i = 0; i < 6; i++)
            c_t_reg[i] <= b_t_reg[i];
    end

    // stage D: nearest face, earlier face wins a tie
    logic                   d_vld_reg;
    rcnh_pkg::ray_t         d_ray_reg;
    logic                   d_hit_reg;
    logic signed [31:0]     d_t_reg;
    logic [2:0]             d_face_reg;
    logic                   d_hit_next;
    logic signed [31:0]     d_t_next;
    logic [2:0]             d_face_next;

    always_comb
    begin
        d_hit_next  = 1'b0;
        d_t_next    = '0;
        d_face_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (c_ok_reg[i] && (!d_hit_next || c_t_reg[i] < d_t_next))
            begin
                d_hit_next  = 1'b1;
                d_t_next    = c_t_reg[i];
                d_face_next = 3'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        d_ray_reg  <= c_ray_reg;
        d_hit_reg  <= d_hit_next;
        d_t_reg    <= d_t_next;
        d_face_reg <= d_face_next;
    end

    // stage E: position products
    logic                   e_vld_reg;
    rcnh_pkg::ray_t         e_ray_reg;
    logic                   e_hit_reg;
    logic signed [31:0]     e_t_reg;
    logic [2:0]             e_face_reg;
    logic signed [63:0]     e_px_reg, e_py_reg, e_pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        e_ray_reg  <= d_ray_reg;
        e_hit_reg  <= d_hit_reg;
        e_t_reg    <= d_t_reg;
        e_face_reg <= d_face_reg;
        e_px_reg   <= d_ray_reg.dx * d_t_reg;
        e_py_reg   <= d_ray_reg.dy * d_t_reg;
        e_pz_reg   <= d_ray_reg.dz * d_t_reg;
    end

    // stage F: output register
    logic                   f_vld_reg;
    logic                   f_hit_reg;
    logic signed [31:0]     f_t_reg, f_x_reg, f_y_reg, f_z_reg;
    logic [1:0]             f_axis_reg;
    logic                   f_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else
            f_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        f_hit_reg <= e_hit_reg;
        if (e_hit_reg)
        begin
            f_t_reg    <= e_t_reg;
            f_x_reg    <= rcnh_pkg::sat32(66'(e_ray_reg.ox)
                                          + rcnh_pkg::fshift(66'(e_px_reg)));
            f_y_reg    <= rcnh_pkg::sat32(66'(e_ray_reg.oy)
                                          + rcnh_pkg::fshift(66'(e_py_reg)));
            f_z_reg    <= rcnh_pkg::sat32(66'(e_ray_reg.oz)
                                          + rcnh_pkg::fshift(66'(e_pz_reg)));
            f_axis_reg <= e_face_reg[2:1];
            f_neg_reg  <= e_face_reg[0];
        end
        else
        begin
            f_t_reg    <= '0;
            f_x_reg    <= '0;
            f_y_reg    <= '0;
            f_z_reg    <= '0;
            f_axis_reg <= rcnh_pkg::AXIS_X;
            f_neg_reg  <= 1'b0;
        end
    end

    assign strobe        = f_vld_reg;
    assign hit           = f_hit_reg;
    assign hit_t         = f_t_reg;
    assign pos_x         = f_x_reg;
    assign pos_y         = f_y_reg;
    assign pos_z         = f_z_reg;
    assign face_axis     = f_axis_reg;
    assign face_negative = f_neg_reg;
endmodule

// File: hw/rtl/ray_cube_nearest_hit.sv
// ray_cube_nearest_hit: top level; setup stage, chain of division cells, face tail.
// Depends on rcnh_pkg, rcnh_div_cell, rcnh_face_tail.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  ray in   | start / busy         | origin_x..z, dir_x..z, min_t, max_t
//  config   | cfg_valid/cfg_ready  | cfg_data (half_side)
//  result   | strobe (no stall)    | hit, hit_t, pos_x..z, face_axis, face_negative
//
// One ray per cycle; busy is tied low. The pipeline is a setup stage, 49 division
// cells (one quotient bit per cell for all six faces) and 6 tail stages.
// Reset clears only the valid bits of the chain and sets half_side to 1.0.
// The receiver cannot stall: each result shows for exactly one cycle.
module ray_cube_nearest_hit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [31:0]  origin_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  logic signed [31:0]  min_t,
    input  logic signed [31:0]  max_t,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [30:0]         cfg_data,
    output logic                strobe,
    output logic                hit,
    output logic signed [31:0]  hit_t,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic [1:0]          face_axis,
    output logic                face_negative
);
    localparam int N = rcnh_pkg::DIV_CELLS;

    logic [30:0]        half_reg;
    logic               s_vld_reg;
    rcnh_pkg::ray_t     s_ray_reg;
    rcnh_pkg::lanes_t   s_lanes_reg;
    rcnh_pkg::ray_t     ray_next;
    rcnh_pkg::lanes_t   lanes_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= rcnh_pkg::HALF_RESET;
        else if (cfg_valid && cfg_ready)
            half_reg <= cfg_data;
    end

    always_comb
    begin
        logic signed [33:0] num;
        logic signed [31:0] d, o;
        logic [33:0]        nm;
        logic [32:0]        dm;
        ray_next = '{ox: origin_x, oy: origin_y, oz: origin_z, dx: dir_x, dy: dir_y,
                     dz: dir_z, lo: min_t, hi: max_t, half: half_reg};
        for (int i = 0; i < 6; i++)
        begin
            d = (i < 2) ? dir_x : (i < 4) ? dir_y : dir_z;
            o = (i < 2) ? origin_x : (i < 4) ? origin_y : origin_z;
            num = (i % 2 == 1) ? -34'($unsigned(half_reg)) - 34'(o)
                               : 34'($unsigned(half_reg)) - 34'(o);
            nm = num[33] ? 34'(-num) : 34'(num);
            dm = d[31] ? 33'(-34'(d)) : 33'(d);
            lanes_next[i].rem  = '0;
            lanes_next[i].num  = {nm[32:0], {rcnh_pkg::FRAC_BITS{1'b0}}};
            lanes_next[i].quo  = '0;
            lanes_next[i].den  = dm[31:0];
            lanes_next[i].qneg = num[33] != d[31];
            lanes_next[i].skip = (d == 32'sd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else
            s_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s_ray_reg   <= ray_next;
        s_lanes_reg <= lanes_next;
    end

    logic               c_vld [N+1];
    rcnh_pkg::ray_t     c_ray [N+1];
    rcnh_pkg::lanes_t   c_lanes [N+1];

    assign c_vld[0]   = s_vld_reg;
    assign c_ray[0]   = s_ray_reg;
    assign c_lanes[0] = s_lanes_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        rcnh_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .vld_in    (c_vld[g]),
            .ray_in    (c_ray[g]),
            .lanes_in  (c_lanes[g]),
            .vld_out   (c_vld[g+1]),
            .ray_out   (c_ray[g+1]),
            .lanes_out (c_lanes[g+1])
        );
    end

    rcnh_face_tail u_tail (
        .clk           (clk),
        .rst_n         (rst_n),
        .vld_in        (c_vld[N]),
        .ray_in        (c_ray[N]),
        .lanes_in      (c_lanes[N]),
        .strobe        (strobe),
        .hit           (hit),
        .hit_t         (hit_t),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .face_axis     (face_axis),
        .face_negative (face_negative)
    );
endmodule

// File: hw/rtl/rcnh_checker.sv
// rcnh_checker: port-level assertions for ray_cube_nearest_hit, bound to the top.
// Depends on ray_cube_nearest_hit ports only.
module rcnh_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                strobe,
    input  logic                hit,
    input  logic signed [31:0]  hit_t,
    input  logic signed [31:0]  pos_x,
    input  logic [1:0]          face_axis,
    input  logic                face_negative
);
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !hit |-> hit_t == 0 && pos_x == 0 && face_axis == 0 && !face_negative)
        else $error("miss result not zero");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> face_axis != 2'd3)
        else $error("bad face axis");

    a_no_strobe_reset: assert property (@(posedge clk)
        !rst_n |=> !strobe)
        else $error("strobe after reset");
endmodule

bind ray_cube_nearest_hit rcnh_checker u_rcnh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .strobe        (strobe),
    .hit           (hit),
    .hit_t         (hit_t),
    .pos_x         (pos_x),
    .face_axis     (face_axis),
    .face_negative (face_negative)
);

// File: sim/ray_cube_nearest_hit_checker.sv
// Checker for ray_cube_nearest_hit: predicts each nearest hit and compares it with the result.
// Depends on rcnh_pkg; watches the ray, config and result channels of the block.
`timescale 1ns / 1ps

module ray_cube_nearest_hit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] min_t,
    input  logic signed [31:0] max_t,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    input  logic               strobe,
    input  logic               hit,
    input  logic signed [31:0] hit_t,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [1:0]         face_axis,
    input  logic               face_negative,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [1:0]         axis;
        logic               neg;
    } hit_rec_t;

    hit_rec_t   hits_due[$];
    logic [30:0] cube_half;

    // exact coordinate: o + floor(d * t / 2^FRAC_BITS)
    function automatic longint coord(longint o, longint d, longint t);
        longint p;
        p = d * t;
        return o + (p >>> rcnh_pkg::FRAC_BITS);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic hit_rec_t nearest_hit(longint o[3], longint d[3], longint lo,
                                             longint hi, logic [30:0] half);
        hit_rec_t r;
        longint h, plane, num, t, best_t, pb, pc;
        longint unsigned q;
        int best_axis, ax, b, c;
        logic neg, best_neg;
        r = '0;
        h = longint'(half);
        best_axis = -1;
        best_t = 0;
        best_neg = 0;
        for (int f = 0; f < 6; f++) begin
            ax = f / 2;
            neg = 1'(f % 2);
            b = (ax + 1) % 3;
            c = (ax + 2) % 3;
            if (d[ax] == 0)
                continue;
            plane = neg ? -h : h;
            num = plane - o[ax];
            q = longint'(unsigned'(num < 0 ? -num : num)) << rcnh_pkg::FRAC_BITS;
            q = q / longint'(unsigned'(d[ax] < 0 ? -d[ax] : d[ax]));
            if ((num < 0) != (d[ax] < 0))
                t = (q > 64'h80000000) ? -64'sd2147483648 : -longint'(q);
            else
                t = (q > 64'h7fffffff) ? 64'sd2147483647 : longint'(q);
            pb = coord(o[b], d[b], t);
            pc = coord(o[c], d[c], t);
            if (pb > h || -pb > h || pc > h || -pc > h)
                continue;
            if (t < lo || t > hi)
                continue;
            if (best_axis < 0 || t < best_t) begin
                best_axis = ax;
                best_neg = neg;
                best_t = t;
            end
        end
        if (best_axis >= 0) begin
            r.hit = 1'b1;
            r.t = 32'(best_t);
            r.px = 32'(clamp32(coord(o[0], d[0], best_t)));
            r.py = 32'(clamp32(coord(o[1], d[1], best_t)));
            r.pz = 32'(clamp32(coord(o[2], d[2], best_t)));
            r.axis = best_axis[1:0];
            r.neg = best_neg;
        end
        return r;
    endfunction

    assign pending = hits_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint o[3], d[3];
        hit_rec_t e;
        if (!rst_n)
        begin
            cube_half <= rcnh_pkg::HALF_RESET;
            hits_due.delete();
            fail_count <= 0;
        end
        else
        begin
            if (strobe)
            begin
                if (hits_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = hits_due.pop_front();
                    if (hit !== e.hit || hit_t !== e.t || pos_x !== e.px || pos_y !== e.py
                        || pos_z !== e.pz || face_axis !== e.axis
                        || face_negative !== e.neg)
                        fail_count <= fail_count + 1;
                    if (hit !== e.hit)
                        $error("hit: expected %0d actual %0d", e.hit, hit);
                    if (hit_t !== e.t)
                        $error("hit_t: expected %0d actual %0d", e.t, hit_t);
                    if (pos_x !== e.px)
                        $error("pos_x: expected %0d actual %0d", e.px, pos_x);
                    if (pos_y !== e.py)
                        $error("pos_y: expected %0d actual %0d", e.py, pos_y);
                    if (pos_z !== e.pz)
                        $error("pos_z: expected %0d actual %0d", e.pz, pos_z);
                    if (face_axis !== e.axis)
                        $error("face_axis: expected %0d actual %0d", e.axis, face_axis);
                    if (face_negative !== e.neg)
                        $error("face_negative: expected %0d actual %0d", e.neg,
                               face_negative);
                end
            end
            if (start && !busy)
            begin
                o[0] = origin_x; o[1] = origin_y; o[2] = origin_z;
                d[0] = dir_x; d[1] = dir_y; d[2] = dir_z;
                hits_due.push_back(nearest_hit(o, d, min_t, max_t, cube_half));
            end
            if (cfg_valid && cfg_ready)
                cube_half <= cfg_data;
        end
    end

endmodule

// File: sim/ray_cube_nearest_hit_tb.sv
// Testbench top for ray_cube_nearest_hit: drives rays and half_side writes, gives the verdict.
// Depends on rcnh_pkg, ray_cube_nearest_hit and ray_cube_nearest_hit_checker.
`timescale 1ns / 1ps

module ray_cube_nearest_hit_tb;

    localparam int LATENCY   = 56;
    localparam int STALL_MAX = 2000;
    localparam int ONE       = 65536;

    logic clk, rst_n, start, busy, cfg_valid, cfg_ready, strobe;
    logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, min_t, max_t;
    logic [30:0] cfg_data;
    logic hit, face_negative;
    logic signed [31:0] hit_t, pos_x, pos_y, pos_z;
    logic [1:0] face_axis;
    int fail_count, pending, idle_cycles;
    logic [30:0] half_now;

    ray_cube_nearest_hit dut (.*);
    ray_cube_nearest_hit_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("ray_cube_nearest_hit regression: fail");
            $finish;
        end
    end

    // start stays high across back-to-back rays; drain drops it
    task automatic send_ray(input logic signed [31:0] v[8]);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        {origin_x, origin_y, origin_z} <= {v[0], v[1], v[2]};
        {dir_x, dir_y, dir_z, min_t, max_t} <= {v[3], v[4], v[5], v[6], v[7]};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain;
        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_half(input logic [30:0] h);
        drain();
        repeat ($urandom_range(0, 4)) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        half_now = h;
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return 0;
            default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
        endcase
    endfunction

    // mostly rays aimed through the cube with random jitter, the rest noise
    task automatic random_ray();
        logic signed [31:0] v[8];
        int hs;
        hs = (half_now > 31'd4000000) ? 4000000 : int'(half_now) + 1;
        if ($urandom_range(0, 4) != 0)
        begin
            for (int k = 0; k < 3; k++)
                v[k] = $signed($urandom_range(0, 6 * hs)) - 3 * hs;
            for (int k = 3; k < 6; k++)
                v[k] = ($urandom_range(0, 5) == 0) ? 0 :
                       $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
            v[6] = ($urandom_range(0, 3) == 0) ? rnd_word() : -32'sd2 * ONE;
            v[7] = ($urandom_range(0, 3) == 0) ? rnd_word() : 32'sh7fffffff;
        end
        else
            for (int k = 0; k < 8; k++)
                v[k] = rnd_word();
        send_ray(v);
    endtask

    task automatic directed_rays();
        logic signed [31:0] v[8];
        // one straight ray at each face
        for (int f = 0; f < 6; f++)
        begin
            v = '{default: 0};
            v[f / 2] = (f % 2) ? -3 * ONE : 3 * ONE;
            v[3 + f / 2] = (f % 2) ? ONE : -ONE;
            v[7] = 32'sh7fffffff;
            send_ray(v);
        end
        v = '{0, 0, 0, 0, 0, 0, 0, 32'sh7fffffff};          // zero direction
        send_ray(v);
        v = '{0, 0, 0, ONE, ONE, ONE, -4 * ONE, 4 * ONE};    // corner tie
        send_ray(v);
        v = '{-5 * ONE, 0, 0, ONE, 0, 0, 5 * ONE, 2 * ONE};  // empty interval
        send_ray(v);
        v = '{32'sh80000000, 0, 0, 1, 0, 0, 0, 32'sh7fffffff}; // t saturates
        send_ray(v);
        v = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, -1, 32'sh80000000, 32'sh7fffffff};
        send_ray(v);
        v = '{-1, -1, -1, -1, -1, -1, -1, -1};
        send_ray(v);
        v = '{0, 5 * ONE, 0, 0, -ONE, 0, 0, ONE};            // outside interval
        send_ray(v);
    endtask

    initial
    begin
        logic [30:0] halves[6];
        rst_n = 0;
        start = 0;
        cfg_valid = 0;
        cfg_data = '0;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, min_t, max_t} = '0;
        idle_cycles = 0;
        half_now = rcnh_pkg::HALF_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        directed_rays();
        halves = '{31'd0, 31'h7fffffff, 31'd1, 31'(3 * ONE), 31'(ONE / 3),
                   rcnh_pkg::HALF_RESET};
        foreach (halves[i])
        begin
            write_half(halves[i]);
            if (i == 0)
                directed_rays();
            for (int n = 0; n < 260; n++)
            begin
                random_ray();
                if (n == 130)
                    drain();
            end
        end
        drain();
        if (fail_count == 0)
            $display("ray_cube_nearest_hit regression: pass");
        else
            $display("ray_cube_nearest_hit regression: fail");
        $finish;
    end

endmodule
